### design/sdf_pkg.sv
// Shared types, constants and helpers for the signed decimal formatter.
// No dependencies; imported by every module of the block.
package sdf_pkg;

  localparam int NumDigits = 10;
  localparam int MagBits   = 32;

  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChMinus = 8'h2D;
  localparam logic [7:0] ChPlus  = 8'h2B;
  localparam logic [7:0] ChSpace = 8'h20;

  typedef enum logic [2:0] {
    CFG_WIDTH = 3'd0,
    CFG_PREC  = 3'd1,
    CFG_LEFT  = 3'd2,
    CFG_PLUS  = 3'd3,
    CFG_SPACE = 3'd4,
    CFG_ZERO  = 3'd5
  } cfg_index_t;

  typedef struct packed {
    logic [5:0] width;
    logic [6:0] prec;
    logic       left;
    logic       plus;
    logic       space;
    logic       zero;
  } cfg_t;

  typedef logic [NumDigits-1:0][3:0] digits_t;

  // Number of significant digits, at least one.
  function automatic logic [3:0] count_digits(input digits_t d);
    logic [3:0] n;
    n = 4'd1;
    for (int i = 1; i < NumDigits; i++) begin
      if (d[i] != 4'd0) n = 4'(i + 1);
    end
    return n;
  endfunction

endpackage

### design/sdf_bcd.sv
// Iterative binary-to-BCD converter: one shift-and-correct step per cycle.
// Depends on sdf_pkg.
module sdf_bcd (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  go,
  input  logic [31:0]           mag,
  output logic                  done,
  output sdf_pkg::digits_t      digits
);
  import sdf_pkg::*;

  logic [MagBits-1:0] shreg;
  logic [5:0]         cnt;
  logic               active;
  digits_t            fixed;

  // Add three to every digit of five or more before the shift.
  always_comb begin
    for (int i = 0; i < NumDigits; i++) begin
      fixed[i] = (digits[i] >= 4'd5) ? digits[i] + 4'd3 : digits[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
      cnt    <= '0;
    end else begin
      done <= 1'b0;
      if (go) begin
        active <= 1'b1;
        cnt    <= 6'(MagBits);
      end else if (active) begin
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          active <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end

  // Shift the corrected digits and the binary word left as one register,
  // so the top bit of the word enters the lowest digit.
  always_ff @(posedge clk) begin
    if (go) begin
      shreg  <= mag;
      digits <= '0;
    end else if (active) begin
      {digits, shreg} <= {fixed, shreg} << 1;
    end
  end

endmodule

### design/sdf_emit.sv
// Sequencer: takes a request, runs the converter, lays out the field, emits
// one character per cycle within each field part. Depends on sdf_pkg, sdf_bcd.
module sdf_emit #(
  parameter int MAX_FIELD = 63
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [31:0]   value,
  input  sdf_pkg::cfg_t cfg,
  output logic          busy,
  output logic          strobe,
  output logic [7:0]    character,
  output logic          last
);
  import sdf_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_CONV  = 8'b0000_0010,
    S_SETUP = 8'b0000_0100,
    S_LEAD  = 8'b0000_1000,
    S_SIGN  = 8'b0001_0000,
    S_ZERO  = 8'b0010_0000,
    S_DIGIT = 8'b0100_0000,
    S_TRAIL = 8'b1000_0000
  } state_t;

  localparam logic [6:0] MaxF = 7'(MAX_FIELD);

  state_t     state, state_next;
  logic       has_sign;
  logic [7:0] sign_ch;
  logic [6:0] lead_cnt, zero_cnt, trail_cnt, remaining;
  logic [3:0] dig_cnt, dig_sel;
  logic       conv_go, conv_done;
  digits_t    digits;
  logic       accept;

  logic       has_prec;
  logic [3:0] nd;
  logic [6:0] width_c, slen, prec_v, prec_c, ndig, body, total, pad, zfill;
  logic       emit_now;
  logic [7:0] emit_ch;

  assign accept  = start && (state == S_IDLE);
  assign busy    = (state != S_IDLE);
  assign conv_go = accept;

  sdf_bcd u_bcd (
    .clk    (clk),
    .rst    (rst),
    .go     (conv_go),
    .mag    (value[31] ? (32'd0 - value) : value),
    .done   (conv_done),
    .digits (digits)
  );

  // Field layout from the digit count and the configuration.
  always_comb begin
    has_prec = ~cfg.prec[6];
    nd       = count_digits(digits);
    width_c  = ({1'b0, cfg.width} > MaxF) ? MaxF : {1'b0, cfg.width};
    slen     = {6'd0, has_sign};
    prec_v   = has_prec ? {1'b0, cfg.prec[5:0]} : 7'd0;
    prec_c   = (prec_v > MaxF - slen) ? (MaxF - slen) : prec_v;
    ndig     = (prec_c > {3'd0, nd}) ? prec_c : {3'd0, nd};
    body     = slen + ndig;
    total    = (width_c > body) ? width_c : body;
    pad      = total - body;
    zfill    = ndig - {3'd0, nd};
  end

  assign dig_sel = dig_cnt - 4'd1;

  always_comb begin
    state_next = state;
    emit_now   = 1'b0;
    emit_ch    = ChSpace;
    case (state)
      S_IDLE:  if (start) state_next = S_CONV;
      S_CONV:  if (conv_done) state_next = S_SETUP;
      S_SETUP: state_next = S_LEAD;
      S_LEAD: begin
        if (lead_cnt == 7'd0) state_next = S_SIGN;
        else emit_now = 1'b1;
      end
      S_SIGN: begin
        emit_now   = has_sign;
        emit_ch    = sign_ch;
        state_next = S_ZERO;
      end
      S_ZERO: begin
        emit_ch = ChZero;
        if (zero_cnt == 7'd0) state_next = S_DIGIT;
        else emit_now = 1'b1;
      end
      S_DIGIT: begin
        emit_ch = ChZero | {4'd0, digits[dig_sel]};
        if (dig_cnt == 4'd0) state_next = S_TRAIL;
        else emit_now = 1'b1;
      end
      S_TRAIL: begin
        if (trail_cnt == 7'd0) state_next = S_IDLE;
        else emit_now = 1'b1;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      strobe <= 1'b0;
    end else begin
      state  <= state_next;
      strobe <= emit_now;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      has_sign <= value[31] | cfg.plus | cfg.space;
      sign_ch  <= value[31] ? ChMinus : (cfg.plus ? ChPlus : ChSpace);
    end
    if (state == S_SETUP) begin
      remaining <= total;
      dig_cnt   <= nd;
      if (cfg.left) begin
        lead_cnt  <= 7'd0;
        zero_cnt  <= zfill;
        trail_cnt <= pad;
      end else if (cfg.zero && !has_prec) begin
        lead_cnt  <= 7'd0;
        zero_cnt  <= pad + zfill;
        trail_cnt <= 7'd0;
      end else begin
        lead_cnt  <= pad;
        zero_cnt  <= zfill;
        trail_cnt <= 7'd0;
      end
    end
    if (emit_now) begin
      character <= emit_ch;
      last      <= (remaining == 7'd1);
      remaining <= remaining - 7'd1;
      if (state == S_LEAD)  lead_cnt  <= lead_cnt - 7'd1;
      if (state == S_ZERO)  zero_cnt  <= zero_cnt - 7'd1;
      if (state == S_DIGIT) dig_cnt   <= dig_cnt - 4'd1;
      if (state == S_TRAIL) trail_cnt <= trail_cnt - 7'd1;
    end
  end

endmodule

### design/signed_decimal_formatter_top.sv
// Signed decimal formatter: renders a 32-bit value as a printf %d field.
// A request passes through the 32 shift steps of the converter, its done
// flag, the setup state and the output register before the first character;
// characters then come one per cycle, with idle cycles between the parts of
// the field. busy stays high until the field is out, and a new request is
// taken only while busy is low. Synchronous active-high reset restores the
// configuration defaults; the result side has no backpressure.
module signed_decimal_formatter_top #(
  parameter int MAX_FIELD = 63
) (
  input  logic               clk,
  input  logic               rst,
  // request channel
  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] value,
  // configuration write channel
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [6:0]         cfg_data,
  // result characters
  output logic               strobe,
  output logic [7:0]         character,
  output logic               last
);
  import sdf_pkg::*;

  cfg_t cfg;

  // The register file takes a write on any cycle; the user must make writes only
  // while the block is idle, so the sequencer sees stable settings (not enforced).
  assign cfg_ready = 1'b1;

  // Hold the configuration; drop writes to unknown indexes.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.width <= 6'd0;
      cfg.prec  <= 7'h7F;
      cfg.left  <= 1'b0;
      cfg.plus  <= 1'b0;
      cfg.space <= 1'b0;
      cfg.zero  <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_WIDTH: cfg.width <= cfg_data[5:0];
        CFG_PREC:  cfg.prec  <= cfg_data;
        CFG_LEFT:  cfg.left  <= cfg_data[0];
        CFG_PLUS:  cfg.plus  <= cfg_data[0];
        CFG_SPACE: cfg.space <= cfg_data[0];
        CFG_ZERO:  cfg.zero  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Sequencer with the shift-and-correct converter inside.
  sdf_emit #(
    .MAX_FIELD (MAX_FIELD)
  ) u_emit (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .value     (value),
    .cfg       (cfg),
    .busy      (busy),
    .strobe    (strobe),
    .character (character),
    .last      (last)
  );

endmodule
